@@ hw/rtl/cwc_pkg.sv @@
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types, codes and helpers for the collation weight comparator.
// ----------------------------------------------------------------------------
package cwc_pkg;

   localparam int TableDepthDefault = 1024;

   localparam int CodeW = 21;
   localparam int PriW  = 16;
   localparam int SecW  = 8;
   localparam int TerW  = 8;
   localparam int WgtW  = PriW + SecW + TerW;
   localparam int CntCfgW = 11;

   // opcodes
   localparam logic OpLoad    = 1'b0;
   localparam logic OpCompare = 1'b1;

   // register indexes
   localparam logic [1:0] CsrTableEnabled = 2'd0;
   localparam logic [1:0] CsrTableEntries = 2'd1;
   localparam logic [1:0] CsrStrength     = 2'd2;

   // strength levels
   localparam logic [1:0] StrengthPrimary  = 2'd0;
   localparam logic [1:0] StrengthTertiary = 2'd2;
   localparam logic [1:0] StrengthReset    = 2'd2;

   // order codes
   localparam logic signed [1:0] OrderLess    = -2'sd1;
   localparam logic signed [1:0] OrderEqual   = 2'sd0;
   localparam logic signed [1:0] OrderGreater = 2'sd1;

   // fallback weights
   localparam logic [PriW-1:0] PrimaryMax    = 16'hFFFF;
   localparam logic [PriW-1:0] MissBase      = 16'd350;
   localparam logic [CodeW-1:0] AsciiLimit   = 21'd128;

   typedef struct packed {
      logic [CodeW-1:0] code;
      logic [PriW-1:0]  primary;
      logic [SecW-1:0]  secondary;
      logic [TerW-1:0]  tertiary;
   } cwc_entry_type;

   typedef struct packed {
      logic       table_enabled;
      logic [1:0] strength;
   } cwc_cfg_type;

   typedef struct packed {
      logic             start;
      logic [CodeW-1:0] code;
   } cwc_srch_req_type;

   typedef struct packed {
      logic            done;
      logic [WgtW-1:0] weight;
   } cwc_srch_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK_A,
      ST_LOOK_B,
      ST_DECIDE
   } cwc_state_type;

   typedef enum logic {
      SS_IDLE,
      SS_PROBE
   } cwc_srch_state_type;

   // primary weight of a code point that is not in the table
   function automatic logic [PriW-1:0] miss_primary(input logic [CodeW-1:0] code);
      logic [PriW-1:0] ascii;
      ascii = {6'b0, code[6:0], 3'b0} + {8'b0, code[6:0], 1'b0};
      if (code < AsciiLimit) begin
         return ascii;
      end else begin
         return MissBase + {4'b0, code[11:0]};
      end
   endfunction

endpackage

@@ hw/rtl/cwc_table.sv @@
// ----------------------------------------------------------------------------
// cwc_table
// Weight table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cwc_table #(
   parameter int TABLE_DEPTH = cwc_pkg::TableDepthDefault,
   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AddrW-1:0]      wr_addr,
   input  cwc_pkg::cwc_entry_type wr_data,
   input  logic [AddrW-1:0]      rd_addr,
   output cwc_pkg::cwc_entry_type rd_data
);
   import cwc_pkg::*;

   cwc_entry_type mem [TABLE_DEPTH];
   cwc_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/cwc_search.sv @@
// ----------------------------------------------------------------------------
// cwc_search
// Shared lookup unit: bisects an enabled, non-empty weight table, one probe per
// cycle, and returns the strength-masked packed weight of one code point.
// ----------------------------------------------------------------------------
module cwc_search #(
   parameter int TABLE_DEPTH = cwc_pkg::TableDepthDefault,
   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CntW  = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cwc_pkg::cwc_cfg_type      cfg,
   input  logic [CntW-1:0]           limit,
   input  cwc_pkg::cwc_srch_req_type srch_req,
   output cwc_pkg::cwc_srch_rsp_type srch_rsp,
   output logic [AddrW-1:0]          rd_addr,
   input  cwc_pkg::cwc_entry_type    rd_data
);
   import cwc_pkg::*;

   cwc_srch_state_type state_ff, state_in;
   logic [CntW-1:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CntW-1:0]    lo_n, hi_n, mid_n;
   logic [CodeW-1:0]   code_ff, code_in;
   logic [PriW-1:0]    pri_ff, pri_in;
   logic [SecW-1:0]    sec_ff, sec_in;
   logic [TerW-1:0]    ter_ff, ter_in;
   logic               done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      code_ff <= code_in;
      pri_ff  <= pri_in;
      sec_ff  <= sec_in;
      ter_ff  <= ter_in;
   end

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      code_in  = code_ff;
      pri_in   = pri_ff;
      sec_in   = sec_ff;
      ter_in   = ter_ff;
      done_in  = 1'b0;
      rd_addr  = mid_ff[AddrW-1:0];
      lo_n     = lo_ff;
      hi_n     = hi_ff;
      mid_n    = mid_ff;
      unique case (state_ff)
         SS_IDLE: begin
            if (srch_req.start) begin
               code_in = srch_req.code;
               sec_in  = '0;
               ter_in  = '0;
               if (!cfg.table_enabled) begin
                  pri_in  = (srch_req.code > {5'b0, PrimaryMax}) ? PrimaryMax
                                                                 : srch_req.code[PriW-1:0];
                  done_in = 1'b1;
               end else if (limit == '0) begin
                  pri_in  = miss_primary(srch_req.code);
                  done_in = 1'b1;
               end else begin
                  lo_in    = '0;
                  hi_in    = limit;
                  mid_in   = limit >> 1;
                  rd_addr  = mid_in[AddrW-1:0];
                  state_in = SS_PROBE;
               end
            end
         end
         SS_PROBE: begin
            if (rd_data.code == code_ff) begin
               pri_in   = rd_data.primary;
               sec_in   = rd_data.secondary;
               ter_in   = rd_data.tertiary;
               done_in  = 1'b1;
               state_in = SS_IDLE;
            end else begin
               if (rd_data.code < code_ff) begin
                  lo_n = mid_ff + CntW'(1);
               end else begin
                  hi_n = mid_ff;
               end
               mid_n = lo_n + ((hi_n - lo_n) >> 1);
               if (lo_n < hi_n) begin
                  lo_in   = lo_n;
                  hi_in   = hi_n;
                  mid_in  = mid_n;
                  rd_addr = mid_n[AddrW-1:0];
               end else begin
                  pri_in   = miss_primary(code_ff);
                  sec_in   = '0;
                  ter_in   = '0;
                  done_in  = 1'b1;
                  state_in = SS_IDLE;
               end
            end
         end
         default: begin
            state_in = SS_IDLE;
         end
      endcase
   end

   assign srch_rsp.done   = done_ff;
   assign srch_rsp.weight = {pri_ff,
                             (cfg.strength != StrengthPrimary) ? sec_ff : '0,
                             (cfg.strength >= StrengthTertiary) ? ter_ff : '0};

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      srch_req.start |-> state_ff == SS_IDLE)
      else $error("lookup started while a search runs");

   a_probe_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == SS_PROBE |-> (lo_ff <= mid_ff) && (mid_ff < hi_ff))
      else $error("probe index outside the search window");

   a_done_ends_search: assert property (@(posedge clock) disable iff (reset)
      done_in |=> state_ff == SS_IDLE)
      else $error("search still running after its result");

endmodule

@@ hw/rtl/collation_weight_compare.sv @@
// ----------------------------------------------------------------------------
// collation_weight_compare
// Three-level collation compare of two code-point strings, one position per
// compare transfer, with a loadable weight table searched by bisection.
//
//   port group | direction | carries
//   req_*      | in        | load entry or compare step, valid/ready
//   rsp_*      | out       | order on the last compare step, valid/ready
//   csr_*      | in        | register writes, no wait
//
// A load transfer leaves the block ready. A compare step where both strings are present
// and the order is open runs two lookups on the shared search unit, A then B, each
// bisecting min(table_entries, TABLE_DEPTH) entries, before its decide state; any
// other compare step goes straight to the decide state.
// A last step holds in its final cycle while a previous order is not taken.
// Reset is synchronous; the table holds no reset value.
// ----------------------------------------------------------------------------
module collation_weight_compare #(
   parameter int TABLE_DEPTH = cwc_pkg::TableDepthDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [9:0]                req_entry_index,
   input  logic [cwc_pkg::CodeW-1:0] req_entry_code,
   input  logic [cwc_pkg::PriW-1:0]  req_entry_primary,
   input  logic [cwc_pkg::SecW-1:0]  req_entry_secondary,
   input  logic [cwc_pkg::TerW-1:0]  req_entry_tertiary,
   input  logic                      req_a_present,
   input  logic [cwc_pkg::CodeW-1:0] req_a_code,
   input  logic                      req_b_present,
   input  logic [cwc_pkg::CodeW-1:0] req_b_code,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [1:0]         rsp_order,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [cwc_pkg::CntCfgW-1:0] csr_wdata
);
   import cwc_pkg::*;

   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW  = $clog2(TABLE_DEPTH + 1);
   localparam int LimW  = (CntW > CntCfgW) ? CntW : CntCfgW;
   localparam logic [LimW-1:0] DepthLim = LimW'(TABLE_DEPTH);

   cwc_state_type        state_ff, state_in;
   logic                 table_enabled_ff;
   logic [CntCfgW-1:0]   table_entries_ff;
   logic [1:0]           strength_ff;
   logic                 a_present_ff, b_present_ff, last_ff;
   logic [CodeW-1:0]     b_code_ff;
   logic [WgtW-1:0]      wa_ff, wa_in, wb_ff, wb_in;
   logic                 decided_ff, decided_in;
   logic signed [1:0]    order_ff, order_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [1:0]    rsp_order_ff, rsp_order_in;

   logic                 accept;
   logic                 dec_n;
   logic signed [1:0]    ord_n;
   logic                 rsp_load;
   logic [LimW-1:0]      entries_ext;
   logic [CntW-1:0]      limit;
   cwc_cfg_type          cfg;
   cwc_srch_req_type     srch_req;
   cwc_srch_rsp_type     srch_rsp;
   logic                 wr_en;
   logic [AddrW-1:0]     wr_addr, rd_addr;
   cwc_entry_type        wr_data, rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         table_enabled_ff <= 1'b0;
         table_entries_ff <= '0;
         strength_ff      <= StrengthReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrTableEnabled: table_enabled_ff <= csr_wdata[0];
            CsrTableEntries: table_entries_ff <= csr_wdata;
            CsrStrength:     strength_ff      <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   assign entries_ext       = LimW'(table_entries_ff);
   assign limit             = CntW'((entries_ext > DepthLim) ? DepthLim : entries_ext);
   assign cfg.table_enabled = table_enabled_ff;
   assign cfg.strength      = strength_ff;

   // table write
   assign wr_en   = accept && (req_opcode == OpLoad) && (32'(req_entry_index) < TABLE_DEPTH);
   assign wr_addr = AddrW'(req_entry_index);
   assign wr_data = '{code:      req_entry_code,
                      primary:   req_entry_primary,
                      secondary: req_entry_secondary,
                      tertiary:  req_entry_tertiary};

   // hold the compare step
   always_ff @(posedge clock) begin
      if (accept && (req_opcode == OpCompare)) begin
         a_present_ff <= req_a_present;
         b_present_ff <= req_b_present;
         b_code_ff    <= req_b_code;
         last_ff      <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         decided_ff   <= 1'b0;
         order_ff     <= OrderEqual;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         decided_ff   <= decided_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wa_ff        <= wa_in;
      wb_ff        <= wb_in;
      rsp_order_ff <= rsp_order_in;
   end

   always_comb begin
      state_in      = state_ff;
      wa_in         = wa_ff;
      wb_in         = wb_ff;
      decided_in    = decided_ff;
      order_in      = order_ff;
      rsp_order_in  = rsp_order_ff;
      rsp_load      = 1'b0;
      srch_req      = '0;
      dec_n         = decided_ff;
      ord_n         = order_ff;

      if (!decided_ff) begin
         if (a_present_ff && b_present_ff) begin
            if (wa_ff != wb_ff) begin
               dec_n = 1'b1;
               ord_n = (wa_ff < wb_ff) ? OrderLess : OrderGreater;
            end
         end else if (a_present_ff) begin
            dec_n = 1'b1;
            ord_n = OrderGreater;
         end else if (b_present_ff) begin
            dec_n = 1'b1;
            ord_n = OrderLess;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OpCompare)) begin
               if (!decided_ff && req_a_present && req_b_present) begin
                  srch_req.start = 1'b1;
                  srch_req.code  = req_a_code;
                  state_in       = ST_LOOK_A;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_LOOK_A: begin
            if (srch_rsp.done) begin
               wa_in          = srch_rsp.weight;
               srch_req.start = 1'b1;
               srch_req.code  = b_code_ff;
               state_in       = ST_LOOK_B;
            end
         end
         ST_LOOK_B: begin
            if (srch_rsp.done) begin
               wb_in    = srch_rsp.weight;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!last_ff) begin
               decided_in = dec_n;
               order_in   = ord_n;
               state_in   = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_order_in = dec_n ? ord_n : OrderEqual;
               decided_in   = 1'b0;
               order_in     = OrderEqual;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_order = rsp_order_ff;

   cwc_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cwc_search #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .limit    (limit),
      .srch_req (srch_req),
      .srch_rsp (srch_rsp),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   a_done_only_in_lookup: assert property (@(posedge clock) disable iff (reset)
      srch_rsp.done |-> (state_ff == ST_LOOK_A) || (state_ff == ST_LOOK_B))
      else $error("lookup result arrived outside a lookup");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> !decided_ff && (order_ff == OrderEqual) && rsp_valid_ff)
      else $error("comparison state not cleared after the order");

   a_order_code_valid: assert property (@(posedge clock) disable iff (reset)
      decided_ff |-> (order_ff == OrderLess) || (order_ff == OrderGreater))
      else $error("decided without a strict order");

endmodule
